// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, held off during arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication checked in the same cycle
`define ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_SAME(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- rtl/rvmc_pkg.sv -----
// ----------------------------------------------------------------------------
// rvmc_pkg
// types, constants and decode helpers of the multicycle rv32i core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rvmc_pkg;

	localparam int Xlen    = 32;
	localparam int NumRegs = 32;
	localparam int RegIdxW = 5;
	localparam int RfAddrW = $clog2(NumRegs);
	localparam int OutW    = 104;

	localparam logic [6:0] OpcLoad   = 7'h03;
	localparam logic [6:0] OpcMisc   = 7'h0F;
	localparam logic [6:0] OpcOpImm  = 7'h13;
	localparam logic [6:0] OpcAuipc  = 7'h17;
	localparam logic [6:0] OpcStore  = 7'h23;
	localparam logic [6:0] OpcOp     = 7'h33;
	localparam logic [6:0] OpcLui    = 7'h37;
	localparam logic [6:0] OpcBranch = 7'h63;
	localparam logic [6:0] OpcJalr   = 7'h67;
	localparam logic [6:0] OpcJal    = 7'h6F;
	localparam logic [6:0] OpcSystem = 7'h73;

	localparam logic [1:0] SizeByte = 2'd0;
	localparam logic [1:0] SizeHalf = 2'd1;
	localparam logic [1:0] SizeWord = 2'd2;

	typedef enum logic [4:0] {
		PH_FETCH   = 5'b00001,
		PH_DECODE  = 5'b00010,
		PH_EXECUTE = 5'b00100,
		PH_BRANCH  = 5'b01000,
		PH_LOADWB  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [2:0] funct3;
		logic       branch;
		logic       reg_reg;
		logic       reg_imm;
		logic       alt;
	} alu_ctrl_t;

	function automatic logic encoding_ok(input logic [Xlen-1:0] w);
		logic [2:0] f3;
		logic       ok;
		f3 = w[14:12];
		ok = 1'b0;
		if (w[1:0] == 2'b11) begin
			case (w[6:0])
				OpcLoad:   ok = (f3 != 3'd3) && (f3 < 3'd6);
				OpcStore:  ok = (f3 < 3'd3);
				OpcBranch: ok = (f3 != 3'd2) && (f3 != 3'd3);
				OpcMisc, OpcOpImm, OpcAuipc, OpcOp,
				OpcLui, OpcJalr, OpcJal, OpcSystem: ok = 1'b1;
				default:   ok = 1'b0;
			endcase
		end
		return ok;
	endfunction

	function automatic logic [Xlen-1:0] immediate(input logic [Xlen-1:0] w);
		logic [Xlen-1:0] imm;
		case (w[6:0])
			OpcStore:         imm = {{20{w[31]}}, w[31:25], w[11:7]};
			OpcBranch:        imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
			OpcLui, OpcAuipc: imm = {w[31:12], 12'b0};
			OpcJal:           imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			default:          imm = {{20{w[31]}}, w[31:20]};
		endcase
		return imm;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rv32i_multicycle_core.sv -----
// ----------------------------------------------------------------------------
// rv32i_multicycle_core
// multicycle rv32i core stepped by a stream, at most one bus request per step
// ----------------------------------------------------------------------------
// Each slave-side request is one clock step of the core and carries the
// memory reply to the previous step's read. Each step gives one master-side
// request with the pc and the bus request, so a step can be taken every
// cycle while the output register is drained. An instruction takes 3 steps
// (fetch, decode, execute), 4 for a taken branch or a load. The register
// file is a two-read ram read during decode, with one valid bit per
// register so it reads as zero after reset without a clearing pass.
// Writing cfg_wdata reloads the pc, returns to fetch and clears the
// illegal-instruction halt; the register file is kept.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rv32i_multicycle_core
	import rvmc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [Xlen-1:0] cfg_wdata,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [31:0]     s_tdata,   // mem_read_data
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	// program_counter, bus_address, access_size, read_request,
	// write_request, write_data, illegal_instruction, zero fill
	output logic [OutW-1:0]      m_tdata
);

	phase_t          phase_q, phase_d;
	logic [Xlen-1:0] pc_q, pc_d;
	logic [Xlen-1:0] ir_q, ir_d;
	logic [Xlen-1:0] operand_a_q, operand_a_d;
	logic [Xlen-1:0] operand_b_q, operand_b_d;
	logic            a_rf_q, a_rf_d;
	logic            b_rf_q, b_rf_d;
	logic            rs1_live_q, rs1_live_d;
	logic            rs2_live_q, rs2_live_d;
	logic            halted_q, halted_d;
	logic [NumRegs-1:0] valid_q;

	logic            accept;
	logic            m_tvalid_q;
	logic [OutW-1:0] m_tdata_q;

	logic [RegIdxW-1:0] rs1_in, rs2_in, rd;
	logic [6:0]         opc;
	logic [2:0]         f3;
	logic [6:0]         opc_in;

	logic               ram_we;
	logic [Xlen-1:0]    ram_wdata;
	logic [Xlen-1:0]    ram_rdata_a, ram_rdata_b;
	logic [Xlen-1:0]    rf_a, rf_b;
	logic [Xlen-1:0]    alu_a, alu_b, alu_res;
	alu_ctrl_t          alu_ctrl;

	logic [Xlen-1:0]    bus_addr;
	logic [1:0]         size;
	logic               rd_req, wr_req;
	logic [Xlen-1:0]    wr_data;
	logic [Xlen-1:0]    load_val;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign rs1_in = s_tdata[19:15];
	assign rs2_in = s_tdata[24:20];
	assign opc_in = s_tdata[6:0];
	assign opc    = ir_q[6:0];
	assign f3     = ir_q[14:12];
	assign rd     = ir_q[11:7];

	// register file, read on the decode step only so the data holds for execute
	rvmc_ram #(
		.Width(Xlen),
		.Depth(NumRegs)
	) u_rf (
		.clk    (clk),
		.we     (ram_we && accept),
		.waddr  (rd[RfAddrW-1:0]),
		.wdata  (ram_wdata),
		.re     (accept && (phase_q == PH_DECODE)),
		.raddr_a(rs1_in[RfAddrW-1:0]),
		.raddr_b(rs2_in[RfAddrW-1:0]),
		.rdata_a(ram_rdata_a),
		.rdata_b(ram_rdata_b)
	);

	assign rf_a  = rs1_live_q ? ram_rdata_a : '0;
	assign rf_b  = rs2_live_q ? ram_rdata_b : '0;
	assign alu_a = a_rf_q ? rf_a : operand_a_q;
	assign alu_b = b_rf_q ? rf_b : operand_b_q;

	assign alu_ctrl.funct3  = f3;
	assign alu_ctrl.branch  = (opc == OpcBranch);
	assign alu_ctrl.reg_reg = (opc == OpcOp);
	assign alu_ctrl.reg_imm = (opc == OpcOpImm);
	assign alu_ctrl.alt     = ir_q[30];

	rvmc_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.ctrl(alu_ctrl),
		.res (alu_res)
	);

	// load reply masked to the size, lb and lh sign-extended
	always_comb begin
		case (f3[1:0])
			SizeByte: load_val = {{24{s_tdata[7] && !f3[2]}}, s_tdata[7:0]};
			SizeHalf: load_val = {{16{s_tdata[15] && !f3[2]}}, s_tdata[15:0]};
			default:  load_val = s_tdata;
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		pc_d        = pc_q;
		ir_d        = ir_q;
		operand_a_d = operand_a_q;
		operand_b_d = operand_b_q;
		a_rf_d      = a_rf_q;
		b_rf_d      = b_rf_q;
		rs1_live_d  = rs1_live_q;
		rs2_live_d  = rs2_live_q;
		halted_d    = halted_q;
		ram_we      = 1'b0;
		ram_wdata   = alu_res;
		bus_addr    = '0;
		size        = SizeByte;
		rd_req      = 1'b0;
		wr_req      = 1'b0;
		wr_data     = '0;
		if (!halted_q) begin
			case (phase_q)
				PH_DECODE: begin
					ir_d = s_tdata;
					if (!encoding_ok(s_tdata)) begin
						halted_d = 1'b1;
					end else begin
						rs1_live_d  = valid_q[rs1_in[RfAddrW-1:0]] && (rs1_in != '0)
							&& (32'(rs1_in) < NumRegs);
						rs2_live_d  = valid_q[rs2_in[RfAddrW-1:0]] && (rs2_in != '0)
							&& (32'(rs2_in) < NumRegs);
						a_rf_d      = !((opc_in == OpcLui) || (opc_in == OpcAuipc)
							|| (opc_in == OpcJal));
						operand_a_d = (opc_in == OpcLui) ? '0 : pc_q;
						b_rf_d      = (opc_in == OpcOp) || (opc_in == OpcBranch);
						operand_b_d = immediate(s_tdata);
						phase_d     = PH_EXECUTE;
					end
				end
				PH_EXECUTE: begin
					phase_d = PH_FETCH;
					case (opc)
						OpcOp, OpcOpImm, OpcLui, OpcAuipc: begin
							ram_we = 1'b1;
							pc_d   = pc_q + 32'd4;
						end
						OpcJal, OpcJalr: begin
							ram_we    = 1'b1;
							ram_wdata = pc_q + 32'd4;
							pc_d      = {alu_res[Xlen-1:1], 1'b0};
						end
						OpcBranch: begin
							if (alu_res[0]) begin
								operand_a_d = pc_q;
								operand_b_d = immediate(ir_q);
								a_rf_d      = 1'b0;
								b_rf_d      = 1'b0;
								phase_d     = PH_BRANCH;
							end else begin
								pc_d = pc_q + 32'd4;
							end
						end
						OpcLoad: begin
							bus_addr = alu_res;
							size     = f3[1:0];
							rd_req   = 1'b1;
							phase_d  = PH_LOADWB;
						end
						OpcStore: begin
							bus_addr = alu_res;
							size     = f3[1:0];
							wr_req   = 1'b1;
							wr_data  = rf_b;
							pc_d     = pc_q + 32'd4;
						end
						default: begin
							pc_d = pc_q + 32'd4;
						end
					endcase
				end
				PH_BRANCH: begin
					pc_d    = operand_a_q + operand_b_q;
					phase_d = PH_FETCH;
				end
				PH_LOADWB: begin
					ram_we    = 1'b1;
					ram_wdata = load_val;
					pc_d      = pc_q + 32'd4;
					phase_d   = PH_FETCH;
				end
				default: begin
					bus_addr = pc_q;
					size     = SizeWord;
					rd_req   = 1'b1;
					phase_d  = PH_DECODE;
				end
			endcase
		end
		// x0 and registers past the file drop their writes
		if ((rd == '0) || (32'(rd) >= NumRegs)) begin
			ram_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FETCH;
			pc_q       <= '0;
			halted_q   <= 1'b0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pc_q     <= cfg_wdata;
				phase_q  <= PH_FETCH;
				halted_q <= 1'b0;
			end else if (accept) begin
				pc_q     <= pc_d;
				phase_q  <= phase_d;
				halted_q <= halted_d;
			end
			if (accept && ram_we) begin
				valid_q[rd[RfAddrW-1:0]] <= 1'b1;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ir_q        <= ir_d;
			operand_a_q <= operand_a_d;
			operand_b_q <= operand_b_d;
			a_rf_q      <= a_rf_d;
			b_rf_q      <= b_rf_d;
			rs1_live_q  <= rs1_live_d;
			rs2_live_q  <= rs2_live_d;
			m_tdata_q   <= {3'b0, halted_d, wr_data, wr_req, rd_req, size, bus_addr, pc_d};
		end
	end

	`ASSERT_NEXT(a_halt_quiet, accept && halted_q && !cfg_we, m_tvalid && m_tdata[100] && !m_tdata[66] && !m_tdata[67], "halted core issued a request")
	`ASSERT_NEXT(a_fetch_word, accept && !halted_q && !cfg_we && (phase_q == PH_FETCH), m_tdata[66] && (m_tdata[65:64] == SizeWord) && (phase_q == PH_DECODE), "fetch step did not request a word")
	`ASSERT_SAME(a_rf_write_phase, accept && ram_we, !halted_q && ((phase_q == PH_EXECUTE) || (phase_q == PH_LOADWB)), "register write outside execute or writeback")
	`ASSERT_SAME(a_one_request, m_tvalid, !(m_tdata[66] && m_tdata[67]), "read and write requested in one step")

endmodule

`default_nettype wire

// ----- rtl/rvmc_ram.sv -----
// ----------------------------------------------------------------------------
// rvmc_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvmc_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr_a,
	input  wire logic [$clog2(Depth)-1:0] raddr_b,
	output logic      [Width-1:0]         rdata_a,
	output logic      [Width-1:0]         rdata_b
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rvmc_alu.sv -----
// ----------------------------------------------------------------------------
// rvmc_alu
// integer alu and branch compare of the rv32i core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvmc_alu
	import rvmc_pkg::*;
(
	input  wire logic [Xlen-1:0] a,
	input  wire logic [Xlen-1:0] b,
	input  wire alu_ctrl_t       ctrl,
	output logic      [Xlen-1:0] res
);

	logic [$clog2(Xlen)-1:0] sh;
	logic                    lt_s;
	logic                    lt_u;

	assign sh   = b[$clog2(Xlen)-1:0];
	assign lt_s = $signed(a) < $signed(b);
	assign lt_u = a < b;

	always_comb begin
		res = '0;
		if (ctrl.branch) begin
			case (ctrl.funct3)
				3'd0:    res = Xlen'(a == b);
				3'd1:    res = Xlen'(a != b);
				3'd4:    res = Xlen'(lt_s);
				3'd5:    res = Xlen'(!lt_s);
				3'd6:    res = Xlen'(lt_u);
				3'd7:    res = Xlen'(!lt_u);
				default: res = '0;
			endcase
		end else if (!ctrl.reg_reg && !ctrl.reg_imm) begin
			res = a + b;
		end else begin
			case (ctrl.funct3)
				3'd0:    res = (ctrl.reg_reg && ctrl.alt) ? a - b : a + b;
				3'd1:    res = a << sh;
				3'd2:    res = Xlen'(lt_s);
				3'd3:    res = Xlen'(lt_u);
				3'd4:    res = a ^ b;
				3'd5:    res = ctrl.alt ? Xlen'($signed(a) >>> sh) : a >> sh;
				3'd6:    res = a | b;
				default: res = a & b;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- dv/rv32i_multicycle_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_multicycle_core_test
// The testbench stands in for the memory. It answers every fetch with an
// instruction word and every load with a data word. A step-by-step predictor
// of the core checks each master-side request field by field. Idling and
// stalls change from phase to phase, and the reset vector is rewritten
// between phases and after every halt.
// ----------------------------------------------------------------------------
module rv32i_multicycle_core_test;
	import rvmc_pkg::*;

	localparam int WatchLimit = 2000;

	localparam logic [2:0] F3Add  = 3'd0;
	localparam logic [2:0] F3Sll  = 3'd1;
	localparam logic [2:0] F3Slt  = 3'd2;
	localparam logic [2:0] F3Sltu = 3'd3;
	localparam logic [2:0] F3Xor  = 3'd4;
	localparam logic [2:0] F3Sr   = 3'd5;
	localparam logic [2:0] F3Or   = 3'd6;
	localparam logic [2:0] F3And  = 3'd7;

	localparam logic [2:0] F3Beq  = 3'd0;
	localparam logic [2:0] F3Bne  = 3'd1;
	localparam logic [2:0] F3Blt  = 3'd4;
	localparam logic [2:0] F3Bge  = 3'd5;
	localparam logic [2:0] F3Bltu = 3'd6;
	localparam logic [2:0] F3Bgeu = 3'd7;

	localparam logic [2:0] F3Lb  = 3'd0;
	localparam logic [2:0] F3Lh  = 3'd1;
	localparam logic [2:0] F3Lw  = 3'd2;
	localparam logic [2:0] F3Lbu = 3'd4;
	localparam logic [2:0] F3Lhu = 3'd5;

	localparam logic [2:0] F3Sb = 3'd0;
	localparam logic [2:0] F3Sh = 3'd1;
	localparam logic [2:0] F3Sw = 3'd2;

	// master-side tdata, most significant field first
	typedef struct packed {
		logic [2:0]  fill;
		logic        illegal_instruction;
		logic [31:0] write_data;
		logic        write_request;
		logic        read_request;
		logic [1:0]  access_size;
		logic [31:0] bus_address;
		logic [31:0] program_counter;
	} step_t;

	class core_trace_scoreboard;
		logic [31:0] reset_pc;
		logic [31:0] pc;
		logic [31:0] ir;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [31:0] regs [NumRegs];
		phase_t      ph;
		logic        halted;
		step_t       awaited[$];
		int          mismatches;

		function new();
			reset_pc = '0;
			pc = '0;
			ir = '0;
			opa = '0;
			opb = '0;
			ph = PH_FETCH;
			halted = 1'b0;
			mismatches = 0;
			foreach (regs[i]) regs[i] = '0;
		endfunction

		function void load_vector(logic [31:0] v);
			reset_pc = v;
			pc = v;
			ph = PH_FETCH;
			halted = 1'b0;
		endfunction

		function logic [31:0] get_reg(logic [4:0] idx);
			if (idx == 5'd0 || idx >= NumRegs)
				return '0;
			return regs[idx];
		endfunction

		function void set_reg(logic [4:0] idx, logic [31:0] v);
			if (idx != 5'd0 && idx < NumRegs)
				regs[idx] = v;
		endfunction

		function bit word_is_legal(logic [31:0] w);
			logic [2:0] f3;
			f3 = w[14:12];
			if (w[1:0] != 2'b11)
				return 1'b0;
			case (w[6:0])
				OpcLoad:   return (f3 != 3'd3) && (f3 <= F3Lhu);
				OpcStore:  return f3 <= F3Sw;
				OpcBranch: return (f3 != 3'd2) && (f3 != 3'd3);
				OpcMisc, OpcOpImm, OpcAuipc, OpcOp,
				OpcLui, OpcJalr, OpcJal, OpcSystem: return 1'b1;
				default:   return 1'b0;
			endcase
		endfunction

		function logic [31:0] imm_of(logic [31:0] w);
			case (w[6:0])
				OpcStore:         return {{20{w[31]}}, w[31:25], w[11:7]};
				OpcBranch:        return {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
				OpcLui, OpcAuipc: return {w[31:12], 12'd0};
				OpcJal:           return {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
				default:          return {{20{w[31]}}, w[31:20]};
			endcase
		endfunction

		function logic [31:0] alu_out(logic [31:0] a, logic [31:0] b, logic [2:0] f3,
				logic [6:0] opc, logic alt);
			logic [4:0]  sh;
			logic [31:0] r;
			sh = b[4:0];
			r = '0;
			if (opc == OpcBranch) begin
				case (f3)
					F3Beq:   r = 32'(a == b);
					F3Bne:   r = 32'(a != b);
					F3Blt:   r = 32'($signed(a) < $signed(b));
					F3Bge:   r = 32'($signed(a) >= $signed(b));
					F3Bltu:  r = 32'(a < b);
					F3Bgeu:  r = 32'(a >= b);
					default: r = '0;
				endcase
			end else if (opc != OpcOp && opc != OpcOpImm) begin
				r = a + b;
			end else begin
				case (f3)
					F3Add:  r = (opc == OpcOp && alt) ? a - b : a + b;
					F3Sll:  r = a << sh;
					F3Slt:  r = 32'($signed(a) < $signed(b));
					F3Sltu: r = 32'(a < b);
					F3Xor:  r = a ^ b;
					// shift kept self-determined so the sign is not lost
					F3Sr:   r = alt ? 32'($signed(a) >>> sh) : a >> sh;
					F3Or:   r = a | b;
					F3And:  r = a & b;
				endcase
			end
			return r;
		endfunction

		// one core step per accepted request
		function void note_reply(logic [31:0] rdata);
			step_t       e;
			logic [31:0] w;
			logic [31:0] res;
			logic [31:0] val;
			logic [6:0]  opc;
			logic [2:0]  f3;
			logic [4:0]  rd;
			e = '0;
			w = ir;
			opc = w[6:0];
			f3 = w[14:12];
			rd = w[11:7];
			if (!halted) begin
				case (ph)
					PH_DECODE: begin
						ir = rdata;
						if (!word_is_legal(rdata)) begin
							halted = 1'b1;
						end else begin
							opc = rdata[6:0];
							if (opc == OpcLui)
								opa = '0;
							else if (opc == OpcAuipc || opc == OpcJal)
								opa = pc;
							else
								opa = get_reg(rdata[19:15]);
							if (opc == OpcOp || opc == OpcBranch)
								opb = get_reg(rdata[24:20]);
							else
								opb = imm_of(rdata);
							ph = PH_EXECUTE;
						end
					end
					PH_EXECUTE: begin
						res = alu_out(opa, opb, f3, opc, w[30]);
						ph = PH_FETCH;
						case (opc)
							OpcOp, OpcOpImm, OpcLui, OpcAuipc: begin
								set_reg(rd, res);
								pc = pc + 32'd4;
							end
							OpcJal, OpcJalr: begin
								set_reg(rd, pc + 32'd4);
								pc = {res[31:1], 1'b0};
							end
							OpcBranch: begin
								if (res[0]) begin
									opa = pc;
									opb = imm_of(w);
									ph = PH_BRANCH;
								end else begin
									pc = pc + 32'd4;
								end
							end
							OpcLoad: begin
								e.bus_address = res;
								e.access_size = f3[1:0];
								e.read_request = 1'b1;
								ph = PH_LOADWB;
							end
							OpcStore: begin
								e.bus_address = res;
								e.access_size = f3[1:0];
								e.write_request = 1'b1;
								e.write_data = get_reg(w[24:20]);
								pc = pc + 32'd4;
							end
							default: pc = pc + 32'd4;
						endcase
					end
					PH_BRANCH: begin
						pc = opa + opb;
						ph = PH_FETCH;
					end
					PH_LOADWB: begin
						// reply bits above the access size are dropped
						if (f3[1:0] == SizeByte)
							val = {{24{f3 == F3Lb && rdata[7]}}, rdata[7:0]};
						else if (f3[1:0] == SizeHalf)
							val = {{16{f3 == F3Lh && rdata[15]}}, rdata[15:0]};
						else
							val = rdata;
						set_reg(rd, val);
						pc = pc + 32'd4;
						ph = PH_FETCH;
					end
					default: begin
						e.bus_address = pc;
						e.access_size = SizeWord;
						e.read_request = 1'b1;
						ph = PH_DECODE;
					end
				endcase
			end
			e.program_counter = pc;
			e.illegal_instruction = halted;
			awaited.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_step(logic [OutW-1:0] raw);
			step_t got;
			step_t want;
			got = step_t'(raw);
			if (awaited.size() == 0) begin
				$display("%0t: step result with none expected, actual %h", $time, raw);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				compare_field("program_counter", want.program_counter, got.program_counter);
				compare_field("bus_address", want.bus_address, got.bus_address);
				compare_field("access_size", 32'(want.access_size), 32'(got.access_size));
				compare_field("read_request", 32'(want.read_request),
					32'(got.read_request));
				compare_field("write_request", 32'(want.write_request),
					32'(got.write_request));
				compare_field("write_data", want.write_data, got.write_data);
				compare_field("illegal_instruction", 32'(want.illegal_instruction),
					32'(got.illegal_instruction));
				compare_field("zero fill", 32'(want.fill), 32'(got.fill));
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_we = 1'b0;
	logic [Xlen-1:0] cfg_wdata = '0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [31:0]     s_tdata = '0;     // mem_read_data
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	// program_counter, bus_address, access_size, read_request,
	// write_request, write_data, illegal_instruction, zero fill
	logic [OutW-1:0] m_tdata;

	core_trace_scoreboard board;
	int gap_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	bit s_taken = 1'b0;

	rv32i_multicycle_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// both sides are sampled in one place so a request is noted before its result
	task automatic tick();
		bit m_taken;
		@(posedge clk);
		s_taken = s_tvalid && s_tready;
		m_taken = m_tvalid && m_tready;
		if (s_taken)
			board.note_reply(s_tdata);
		if (m_taken)
			board.check_step(m_tdata);
		quiet_cycles = (s_taken || m_taken) ? 0 : quiet_cycles + 1;
		m_tready <= ($urandom_range(99) >= stall_pct);
	endtask

	task automatic send_step(input logic [31:0] data);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			tick();
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		do tick(); while (!s_taken);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do tick(); while (board.outstanding() != 0);
		repeat (4) tick();
	endtask

	task automatic write_vector(input logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		tick();
		cfg_we <= 1'b0;
		board.load_vector(v);
	endtask

	// fetch, then the word, then whatever steps the instruction still needs
	task automatic run_instr(input logic [31:0] word, input logic [31:0] load_word);
		while (board.ph != PH_DECODE)
			send_step($urandom);
		send_step(word);
		while (!board.halted && board.ph != PH_FETCH)
			send_step(board.ph == PH_LOADWB ? load_word : 32'($urandom));
		// a halted core still answers every request
		if (board.halted)
			repeat (3) send_step($urandom);
	endtask

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OpcOp};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OpcStore};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpcBranch};
	endfunction

	// mostly legal words with random fields, now and then an illegal one
	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		int          r;
		w = $urandom;
		if ($urandom_range(99) < 2) begin
			case ($urandom_range(3))
				0: begin
					while (board.word_is_legal(w))
						w = $urandom;
				end
				1: begin
					// reserved load widths
					w[6:0] = OpcLoad;
					r = $urandom_range(2);
					w[14:12] = (r == 0) ? 3'd3 : (r == 1) ? 3'd6 : 3'd7;
				end
				2: begin
					w[6:0] = OpcStore;
					w[14:12] = 3'($urandom_range(7, 3));
				end
				default: begin
					w[6:0] = OpcBranch;
					w[14:12] = 3'($urandom_range(3, 2));
				end
			endcase
		end else begin
			r = $urandom_range(13);
			case (r)
				0: begin
					w[6:0] = OpcLoad;
					case ($urandom_range(4))
						0: w[14:12] = F3Lb;
						1: w[14:12] = F3Lh;
						2: w[14:12] = F3Lw;
						3: w[14:12] = F3Lbu;
						default: w[14:12] = F3Lhu;
					endcase
				end
				1: begin
					w[6:0] = OpcStore;
					case ($urandom_range(2))
						0: w[14:12] = F3Sb;
						1: w[14:12] = F3Sh;
						default: w[14:12] = F3Sw;
					endcase
				end
				2: begin
					w[6:0] = OpcBranch;
					case ($urandom_range(5))
						0: w[14:12] = F3Beq;
						1: w[14:12] = F3Bne;
						2: w[14:12] = F3Blt;
						3: w[14:12] = F3Bge;
						4: w[14:12] = F3Bltu;
						default: w[14:12] = F3Bgeu;
					endcase
				end
				3, 11, 12: w[6:0] = OpcOpImm;
				4, 13:     w[6:0] = OpcOp;
				5:         w[6:0] = OpcLui;
				6:         w[6:0] = OpcAuipc;
				7:         w[6:0] = OpcJal;
				8:         w[6:0] = OpcJalr;
				9:         w[6:0] = OpcMisc;
				default:   w[6:0] = OpcSystem;
			endcase
		end
		return w;
	endfunction

	initial begin
		wait (quiet_cycles >= WatchLimit);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_vector(32'h0000_1000);

		run_instr({20'h80000, 5'd1, OpcLui}, '0);
		run_instr(enc_i(12'hFFF, 5'd0, F3Add, 5'd2, OpcOpImm), '0);
		// x0 keeps reading zero after a write
		run_instr(enc_r(7'h00, 5'd2, 5'd1, F3Add, 5'd0), '0);
		run_instr(enc_r(7'h20, 5'd2, 5'd1, F3Add, 5'd3), '0);
		run_instr(enc_i({7'h20, 5'd31}, 5'd1, F3Sr, 5'd4, OpcOpImm), '0);
		run_instr(enc_r(7'h00, 5'd2, 5'd1, F3Slt, 5'd5), '0);
		run_instr(enc_r(7'h00, 5'd2, 5'd1, F3Sltu, 5'd6), '0);
		run_instr({20'hFFFFF, 5'd7, OpcAuipc}, '0);
		// loads with reply bits set above the access size
		run_instr(enc_i(12'hFFF, 5'd1, F3Lb, 5'd8, OpcLoad), 32'hFFFF_FF80);
		run_instr(enc_i(12'h7FF, 5'd0, F3Lh, 5'd9, OpcLoad), 32'h1234_8001);
		run_instr(enc_i(12'h000, 5'd2, F3Lbu, 5'd10, OpcLoad), 32'hFFFF_FFFF);
		run_instr(enc_i(12'h800, 5'd2, F3Lhu, 5'd11, OpcLoad), 32'hABCD_F00F);
		run_instr(enc_i(12'h001, 5'd1, F3Lw, 5'd12, OpcLoad), 32'hDEAD_BEEF);
		run_instr(enc_s(12'hFFF, 5'd12, 5'd2, F3Sb), '0);
		run_instr(enc_s(12'h7FF, 5'd8, 5'd1, F3Sh), '0);
		run_instr(enc_s(12'h000, 5'd3, 5'd0, F3Sw), '0);
		run_instr(enc_b(13'h0008, 5'd1, 5'd1, F3Beq), '0);
		run_instr(enc_b(13'h1FFC, 5'd1, 5'd1, F3Bne), '0);
		run_instr(enc_b(13'h1000, 5'd2, 5'd1, F3Blt), '0);
		run_instr(enc_b(13'h0FFE, 5'd1, 5'd2, F3Bgeu), '0);
		run_instr({1'b1, 10'h000, 1'b0, 8'h00, 5'd13, OpcJal}, '0);
		// odd jump target, only bit 0 is cleared
		run_instr(enc_i(12'h000, 5'd2, F3Add, 5'd15, OpcJalr), '0);
		run_instr(enc_i(12'h000, 5'd0, F3Add, 5'd0, OpcMisc), '0);
		run_instr({25'd0, OpcSystem}, '0);
		run_instr(32'h0000_0000, '0);

		for (int p = 0; p < 4; p++) begin
			gap_pct = (p == 1) ? 48 : (p == 3) ? 32 : 0;
			stall_pct = (p == 2) ? 48 : (p == 3) ? 32 : 0;
			write_vector((p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'hFFFF_FFFC :
				(p == 2) ? 32'h0000_0000 : 32'($urandom));
			repeat (45) begin
				run_instr(rand_word(), $urandom);
				if (board.halted)
					write_vector($urandom);
			end
		end

		drain();
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rvmc_pkg.sv
rtl/rvmc_ram.sv
rtl/rvmc_alu.sv
rtl/rv32i_multicycle_core.sv
dv/rv32i_multicycle_core_test.sv
